/* rtl/gcbs_pkg.sv */
`timescale 1ns / 1ps
// types, codes and helpers shared by the grid cell bracket search block
// no dependencies
package gcbs_pkg;

   localparam int COORD_W     = 32;
   localparam int MARGIN_W    = 31;
   localparam int COUNT_W     = 11;
   localparam int OUT_IDX_W   = 10;
   localparam int SCAN_IDX_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int REQ_TDATA_W = 112;
   localparam int RSP_TDATA_W = 80;

   // input op codes
   localparam logic [1:0] OP_LOAD_LAT = 2'd0;
   localparam logic [1:0] OP_LOAD_LON = 2'd1;
   localparam logic [1:0] OP_QUERY    = 2'd2;

   // result zone codes
   localparam logic [2:0] ZONE_INSIDE  = 3'd0;
   localparam logic [2:0] ZONE_LAT_EXT = 3'd1;
   localparam logic [2:0] ZONE_LON_EXT = 3'd2;
   localparam logic [2:0] ZONE_CORNER  = 3'd3;
   localparam logic [2:0] ZONE_ERROR   = 3'd4;

   // configuration register indexes
   localparam logic [2:0] CSR_LAT_COUNT  = 3'd0;
   localparam logic [2:0] CSR_LON_COUNT  = 3'd1;
   localparam logic [2:0] CSR_LAT_MARGIN = 3'd2;
   localparam logic [2:0] CSR_LON_MARGIN = 3'd3;
   localparam logic [2:0] CSR_LAT_MIN    = 3'd4;
   localparam logic [2:0] CSR_LAT_MAX    = 3'd5;
   localparam logic [2:0] CSR_LON_MIN    = 3'd6;
   localparam logic [2:0] CSR_LON_MAX    = 3'd7;

   typedef enum logic [1:0] {
      KIND_LOAD_LAT,
      KIND_LOAD_LON,
      KIND_QUERY
   } kind_type;

   // queued command: load uses a as value, query uses a = lat and b = lon
   typedef struct packed {
      kind_type               kind;
      logic [OUT_IDX_W-1:0]   idx;
      logic [COORD_W-1:0]     a;
      logic [COORD_W-1:0]     b;
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  lat_count;
      logic [COUNT_W-1:0]  lon_count;
      logic [MARGIN_W-1:0] lat_margin;
      logic [MARGIN_W-1:0] lon_margin;
      logic [COORD_W-1:0]  lat_min;
      logic [COORD_W-1:0]  lat_max;
      logic [COORD_W-1:0]  lon_min;
      logic [COORD_W-1:0]  lon_max;
   } cfg_type;

   typedef struct packed {
      logic                  done;
      logic                  ok;
      logic [SCAN_IDX_W-1:0] lo;
      logic [SCAN_IDX_W-1:0] hi;
      logic [COORD_W-1:0]    first;
      logic [COORD_W-1:0]    last;
   } scan_res_type;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_END0,
      SCAN_END1,
      SCAN_END2,
      SCAN_FWD,
      SCAN_REV,
      SCAN_DONE
   } scan_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_SCAN,
      BACK_FLAG,
      BACK_RESULT
   } back_state_type;

   // a lies at or beyond b by no more than margin
   function automatic logic beyond(input logic [COORD_W-1:0] a,
                                   input logic [COORD_W-1:0] b,
                                   input logic [MARGIN_W-1:0] m);
      logic [COORD_W:0] diff;
      diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      return !diff[COORD_W] && (diff <= {2'b00, m});
   endfunction

   // bit 1: hit, bit 0: hit on the last entry
   function automatic logic [1:0] end_match(input logic [COORD_W-1:0] v,
                                            input logic [COORD_W-1:0] first,
                                            input logic [COORD_W-1:0] last);
      logic [1:0] r;
      r = 2'b00;
      if (v == first) begin
         r = 2'b10;
      end else if (v == last) begin
         r = 2'b11;
      end
      return r;
   endfunction

endpackage

/* rtl/gcbs_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module gcbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gcbs_front.sv */
`timescale 1ns / 1ps
// front part: accepts request transactions, classifies them, two-entry queue
// depends on gcbs_pkg
module gcbs_front #(
   parameter int AXIS_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  logic [gcbs_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                  head_valid,
   output gcbs_pkg::cmd_type     head_cmd,
   input  logic                  head_pop
);
   import gcbs_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    cmd;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       keep;
   logic       push;
   logic       pop;
   logic [31:0] idx_wide;

   // classify the incoming transaction
   always_comb begin
      idx_wide = {22'b0, req_tdata[9:0]};
      cmd.idx  = req_tdata[9:0];
      cmd.a    = req_tdata[41:10];
      cmd.b    = req_tdata[73:42];
      cmd.kind = KIND_QUERY;
      keep     = 1'b0;
      unique case (req_tuser)
         OP_LOAD_LAT: begin
            cmd.kind = KIND_LOAD_LAT;
            keep     = idx_wide < AXIS_DEPTH;
         end
         OP_LOAD_LON: begin
            cmd.kind = KIND_LOAD_LON;
            keep     = idx_wide < AXIS_DEPTH;
         end
         OP_QUERY: begin
            cmd.a    = req_tdata[73:42];
            cmd.b    = req_tdata[105:74];
            keep     = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_tready = count_ff != 2'd2;
   assign push       = req_tvalid && req_tready && keep;
   assign pop        = head_pop && head_valid;
   assign head_valid = count_ff != 2'd0;
   assign head_cmd   = q_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push)
      else $error("push into full queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not grow");

endmodule

/* rtl/gcbs_scan.sv */
`timescale 1ns / 1ps
// one axis: stored entries and the forward / reverse bracket scan
// depends on gcbs_pkg, gcbs_ram
module gcbs_scan #(
   parameter int AXIS_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(AXIS_DEPTH)-1:0] wr_addr,
   input  logic [gcbs_pkg::COORD_W-1:0]  wr_data,
   input  logic                          start,
   input  logic [gcbs_pkg::COORD_W-1:0]  coord,
   input  logic [$clog2(AXIS_DEPTH)-1:0] last_idx,
   output gcbs_pkg::scan_res_type        res
);
   import gcbs_pkg::*;

   localparam int IW = $clog2(AXIS_DEPTH);

   scan_state_type      state_ff, state_in;
   logic [IW-1:0]       addr_ff, addr_in;
   logic [IW-1:0]       chk_idx_ff, chk_idx_in;
   logic                chk_vld_ff, chk_vld_in;
   logic                iss_ff, iss_in;
   logic [IW-1:0]       last_ff, last_in;
   logic [COORD_W-1:0]  q_ff, q_in;
   logic [COORD_W-1:0]  first_v_ff, first_v_in;
   logic [COORD_W-1:0]  last_v_ff, last_v_in;
   logic                ok_ff, ok_in;
   logic [IW-1:0]       lo_ff, lo_in;
   logic [IW-1:0]       hi_ff, hi_in;
   logic [IW-1:0]       rd_addr;
   logic [COORD_W-1:0]  rd_data;
   logic                ge;
   logic [31:0]         lo_wide;
   logic [31:0]         hi_wide;

   gcbs_ram #(.WIDTH(COORD_W), .DEPTH(AXIS_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ge = $signed(rd_data) >= $signed(q_ff);

   // scan sequencer: one read issued and one entry checked per cycle
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      chk_idx_in = chk_idx_ff;
      chk_vld_in = 1'b0;
      iss_in     = iss_ff;
      last_in    = last_ff;
      q_in       = q_ff;
      first_v_in = first_v_ff;
      last_v_in  = last_v_ff;
      ok_in      = ok_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      rd_addr    = addr_ff;
      unique case (state_ff)
         SCAN_IDLE, SCAN_DONE: begin
            if (start) begin
               state_in = SCAN_END0;
               q_in     = coord;
               last_in  = last_idx;
               ok_in    = 1'b0;
               lo_in    = '0;
               hi_in    = '0;
            end
         end
         SCAN_END0: begin
            rd_addr  = '0;
            state_in = SCAN_END1;
         end
         SCAN_END1: begin
            rd_addr    = last_ff;
            first_v_in = rd_data;
            state_in   = SCAN_END2;
         end
         SCAN_END2: begin
            last_v_in = rd_data;
            addr_in   = '0;
            iss_in    = 1'b1;
            state_in  = SCAN_FWD;
         end
         SCAN_FWD: begin
            // issue side
            if (iss_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = addr_ff;
               if (addr_ff == last_ff) begin
                  iss_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            // check side
            if (chk_vld_ff) begin
               if (ge && chk_idx_ff != '0) begin
                  ok_in      = 1'b1;
                  lo_in      = chk_idx_ff - 1'b1;
                  hi_in      = chk_idx_ff;
                  chk_vld_in = 1'b0;
                  state_in   = SCAN_DONE;
               end else if (ge || chk_idx_ff == last_ff) begin
                  chk_vld_in = 1'b0;
                  addr_in    = last_ff;
                  iss_in     = 1'b1;
                  state_in   = SCAN_REV;
               end
            end
         end
         SCAN_REV: begin
            if (iss_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = addr_ff;
               if (addr_ff == '0) begin
                  iss_in = 1'b0;
               end else begin
                  addr_in = addr_ff - 1'b1;
               end
            end
            if (chk_vld_ff) begin
               if (ge) begin
                  chk_vld_in = 1'b0;
                  state_in   = SCAN_DONE;
                  if (chk_idx_ff != last_ff) begin
                     ok_in = 1'b1;
                     lo_in = chk_idx_ff;
                     hi_in = chk_idx_ff + 1'b1;
                  end
               end else if (chk_idx_ff == '0) begin
                  chk_vld_in = 1'b0;
                  state_in   = SCAN_DONE;
               end
            end
         end
         default: state_in = SCAN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SCAN_IDLE;
         chk_vld_ff <= 1'b0;
         iss_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         iss_ff     <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      chk_idx_ff <= chk_idx_in;
      last_ff    <= last_in;
      q_ff       <= q_in;
      first_v_ff <= first_v_in;
      last_v_ff  <= last_v_in;
      ok_ff      <= ok_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
   end

   // result view
   always_comb begin
      lo_wide   = 32'(lo_ff);
      hi_wide   = 32'(hi_ff);
      res.done  = state_ff == SCAN_DONE;
      res.ok    = ok_ff;
      res.lo    = lo_wide[SCAN_IDX_W-1:0];
      res.hi    = hi_wide[SCAN_IDX_W-1:0];
      res.first = first_v_ff;
      res.last  = last_v_ff;
   end

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == SCAN_IDLE || state_ff == SCAN_DONE)
      else $error("axis write during scan");
   a_bracket_adjacent: assert property (@(posedge clock) disable iff (reset)
      $rose(res.done) && ok_ff |-> hi_ff == lo_ff + 1'b1)
      else $error("bracket indices not adjacent");
   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> chk_idx_ff <= last_ff)
      else $error("scan index past last entry");

endmodule

/* rtl/gcbs_back.sv */
`timescale 1ns / 1ps
// back part: runs loads and queries, classifies zones, holds the result register
// depends on gcbs_pkg, gcbs_scan
module gcbs_back #(
   parameter int AXIS_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gcbs_pkg::cfg_type                 cfg,
   input  logic                              head_valid,
   input  gcbs_pkg::cmd_type                 head_cmd,
   output logic                              head_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2:0]                        rsp_tuser,
   output logic [gcbs_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import gcbs_pkg::*;

   localparam int IW = $clog2(AXIS_DEPTH);

   back_state_type    state_ff, state_in;
   logic [COORD_W-1:0] lat_ff, lat_in;
   logic [COORD_W-1:0] lon_ff, lon_in;
   logic [IW-1:0]     lat_last_ff, lat_last_in;
   logic [IW-1:0]     lon_last_ff, lon_last_in;
   logic              north_ff, south_ff, west_ff, east_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        zone_ff;
   logic [RSP_TDATA_W-1:0] data_ff;
   logic              load_rsp;
   logic              start;
   logic              lat_wr, lon_wr;
   logic [31:0]       wr_wide;
   logic [IW-1:0]     wr_addr;
   scan_res_type      lat_res, lon_res;
   logic [2:0]        zone;
   logic [OUT_IDX_W-1:0] r_lat_lo, r_lat_hi, r_lon_lo, r_lon_hi;
   logic [OUT_IDX_W-1:0] r_lat_edge, r_lon_edge, r_c_lat, r_c_lon;
   logic [31:0]       lat_last_w, lon_last_w;
   logic              err, lat_ext, lon_ext, corner;
   logic [1:0]        m, ma, mo;
   logic [COORD_W-1:0] cla, clo;

   // effective last index from a count register
   function automatic logic [IW-1:0] last_of(input logic [COUNT_W-1:0] c);
      logic [31:0] cw;
      logic [31:0] r;
      cw = {21'b0, c};
      if (cw < 32'd2) begin
         r = 32'd1;
      end else if (cw > AXIS_DEPTH) begin
         r = AXIS_DEPTH - 1;
      end else begin
         r = cw - 32'd1;
      end
      return r[IW-1:0];
   endfunction

   assign wr_wide = {22'b0, head_cmd.idx};
   assign wr_addr = wr_wide[IW-1:0];

   gcbs_scan #(.AXIS_DEPTH(AXIS_DEPTH)) u_lat (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (lat_wr),
      .wr_addr  (wr_addr),
      .wr_data  (head_cmd.a),
      .start    (start),
      .coord    (head_cmd.a),
      .last_idx (last_of(cfg.lat_count)),
      .res      (lat_res)
   );

   gcbs_scan #(.AXIS_DEPTH(AXIS_DEPTH)) u_lon (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (lon_wr),
      .wr_addr  (wr_addr),
      .wr_data  (head_cmd.a),
      .start    (start),
      .coord    (head_cmd.b),
      .last_idx (last_of(cfg.lon_count)),
      .res      (lon_res)
   );

   // sequencer over queued commands
   always_comb begin
      state_in    = state_ff;
      lat_in      = lat_ff;
      lon_in      = lon_ff;
      lat_last_in = lat_last_ff;
      lon_last_in = lon_last_ff;
      head_pop    = 1'b0;
      start       = 1'b0;
      lat_wr      = 1'b0;
      lon_wr      = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               unique case (head_cmd.kind)
                  KIND_LOAD_LAT: lat_wr = 1'b1;
                  KIND_LOAD_LON: lon_wr = 1'b1;
                  KIND_QUERY: begin
                     start       = 1'b1;
                     lat_in      = head_cmd.a;
                     lon_in      = head_cmd.b;
                     lat_last_in = last_of(cfg.lat_count);
                     lon_last_in = last_of(cfg.lon_count);
                     state_in    = BACK_SCAN;
                  end
                  default: head_pop = 1'b1;
               endcase
            end
         end
         BACK_SCAN: begin
            if (lat_res.done && lon_res.done) begin
               state_in = BACK_FLAG;
            end
         end
         BACK_FLAG: state_in = BACK_RESULT;
         BACK_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // zone classification from the margin flags and axis ends
   always_comb begin
      lat_last_w = 32'(lat_last_ff);
      lon_last_w = 32'(lon_last_ff);
      err        = 1'b0;
      lat_ext    = 1'b0;
      lon_ext    = 1'b0;
      corner     = 1'b0;
      r_lat_lo   = '0;
      r_lat_hi   = '0;
      r_lon_lo   = '0;
      r_lon_hi   = '0;
      r_lat_edge = '0;
      r_lon_edge = '0;
      r_c_lat    = '0;
      r_c_lon    = '0;
      m          = 2'b00;
      ma         = 2'b00;
      mo         = 2'b00;
      cla        = '0;
      clo        = '0;
      zone       = ZONE_INSIDE;
      if (lat_res.ok) begin
         r_lat_lo = lat_res.lo[OUT_IDX_W-1:0];
         r_lat_hi = lat_res.hi[OUT_IDX_W-1:0];
      end
      if (lon_res.ok) begin
         r_lon_lo = lon_res.lo[OUT_IDX_W-1:0];
         r_lon_hi = lon_res.hi[OUT_IDX_W-1:0];
      end
      if (!(lat_res.ok && lon_res.ok)) begin
         // latitude extension
         if (lon_res.ok && !lat_res.ok && (north_ff || south_ff)) begin
            lat_ext = 1'b1;
            m = end_match(north_ff ? cfg.lat_max : cfg.lat_min,
                          lat_res.first, lat_res.last);
            if (!m[1]) begin
               err = 1'b1;
            end else if (m[0]) begin
               r_lat_edge = lat_last_w[OUT_IDX_W-1:0];
            end
         end
         // longitude extension
         if (lat_res.ok && !lon_res.ok && (west_ff || east_ff)) begin
            lon_ext = 1'b1;
            m = end_match(west_ff ? cfg.lon_min : cfg.lon_max,
                          lon_res.first, lon_res.last);
            if (!m[1]) begin
               err = 1'b1;
            end else if (m[0]) begin
               r_lon_edge = lon_last_w[OUT_IDX_W-1:0];
            end
         end
         // corner zone
         if (!err && (north_ff || south_ff) && (west_ff || east_ff)) begin
            cla = north_ff ? cfg.lat_max : cfg.lat_min;
            clo = west_ff ? cfg.lon_min : cfg.lon_max;
            ma  = end_match(cla, lat_res.first, lat_res.last);
            mo  = end_match(clo, lon_res.first, lon_res.last);
            if (!ma[1] || !mo[1]) begin
               err = 1'b1;
            end else begin
               corner  = 1'b1;
               r_c_lat = ma[0] ? lat_last_w[OUT_IDX_W-1:0] : '0;
               r_c_lon = mo[0] ? lon_last_w[OUT_IDX_W-1:0] : '0;
            end
         end
         if (!lat_ext && !lon_ext && !corner) begin
            err = 1'b1;
         end
         priority if (err) begin
            zone = ZONE_ERROR;
         end else if (corner) begin
            zone = ZONE_CORNER;
         end else if (lat_ext) begin
            zone = ZONE_LAT_EXT;
         end else begin
            zone = ZONE_LON_EXT;
         end
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || load_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // query operands, margin flags and result register
   always_ff @(posedge clock) begin
      lat_ff      <= lat_in;
      lon_ff      <= lon_in;
      lat_last_ff <= lat_last_in;
      lon_last_ff <= lon_last_in;
      north_ff    <= beyond(lat_ff, cfg.lat_max, cfg.lat_margin);
      south_ff    <= beyond(cfg.lat_min, lat_ff, cfg.lat_margin);
      west_ff     <= beyond(cfg.lon_min, lon_ff, cfg.lon_margin);
      east_ff     <= beyond(lon_ff, cfg.lon_max, cfg.lon_margin);
      if (load_rsp) begin
         zone_ff <= zone;
         if (zone == ZONE_ERROR) begin
            data_ff <= '0;
         end else begin
            data_ff <= {r_c_lon, r_c_lat, r_lon_edge, r_lat_edge,
                        r_lon_hi, r_lon_lo, r_lat_hi, r_lat_lo};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = zone_ff;
   assign rsp_tdata  = data_ff;

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && zone_ff == ZONE_ERROR |-> data_ff == '0)
      else $error("error result carries indices");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten");
   a_inside_adjacent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && zone_ff == ZONE_INSIDE |->
         data_ff[19:10] == data_ff[9:0] + 10'd1)
      else $error("inside result with bad latitude bracket");

endmodule

/* rtl/grid_cell_bracket_search.sv */
`timescale 1ns / 1ps
// top level of the grid cell bracket search: configuration registers,
// front queue and back engine; depends on gcbs_pkg, gcbs_front, gcbs_back
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tuser op, tdata index/value/lat/lon
// rsp      out  rsp_tvalid/rsp_tready  tuser zone, tdata eight indices
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// a load is written to its axis ram straight from the idle state; a query's
// length is set by the larger axis: each axis ram is read once per cycle,
// forward then reverse, both axes in parallel.
// the two-entry queue takes new transactions while a query runs.
// reset is synchronous; axis memories are not cleared and need loading.
// csr_ready is always high; write only while the block is idle.
module grid_cell_bracket_search #(
   parameter int AXIS_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,    // op
   input  logic [111:0] req_tdata,    // entry_index, entry_value, query_lat, query_lon
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,    // zone
   output logic [79:0]  rsp_tdata,    // lat_low, lat_high, lon_low, lon_high,
                                      // lat_edge, lon_edge, corner_lat, corner_lon
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import gcbs_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    head_valid;
   cmd_type head_cmd;
   logic    head_pop;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LAT_COUNT:  cfg_in.lat_count  = csr_data[COUNT_W-1:0];
            CSR_LON_COUNT:  cfg_in.lon_count  = csr_data[COUNT_W-1:0];
            CSR_LAT_MARGIN: cfg_in.lat_margin = csr_data[MARGIN_W-1:0];
            CSR_LON_MARGIN: cfg_in.lon_margin = csr_data[MARGIN_W-1:0];
            CSR_LAT_MIN:    cfg_in.lat_min    = csr_data;
            CSR_LAT_MAX:    cfg_in.lat_max    = csr_data;
            CSR_LON_MIN:    cfg_in.lon_min    = csr_data;
            CSR_LON_MAX:    cfg_in.lon_max    = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{lat_count: COUNT_W'(2), lon_count: COUNT_W'(2),
                     lat_margin: '0, lon_margin: '0,
                     lat_min: '0, lat_max: '0, lon_min: '0, lon_max: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gcbs_front #(.AXIS_DEPTH(AXIS_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop)
   );

   gcbs_back #(.AXIS_DEPTH(AXIS_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
